/* rtl/gtg_pkg.sv */
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants for the go-to-goal steering block
// Holds the configuration record, the CORDIC seed record passed from the
// front end to the back end, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Datapath width of the CORDIC x, y and z registers (signed)
  localparam int CW = 28;
  // Width of the distance value in Q.12
  localparam int DW = 18;
  // Entries in the arctangent table
  localparam int ATAN_ENTRIES = 24;
  // Depth of the queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // pi in Q.24 radians
  localparam logic signed [CW-1:0] PI_Q24 = 28'sd52707179;
  // Inverse CORDIC gain 0.6072529 in Q.16
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  // Configuration register indexes
  localparam logic [2:0] CFG_GOAL_X        = 3'd0;
  localparam logic [2:0] CFG_GOAL_Y        = 3'd1;
  localparam logic [2:0] CFG_GAIN_LINEAR   = 3'd2;
  localparam logic [2:0] CFG_GAIN_ANGULAR  = 3'd3;
  localparam logic [2:0] CFG_STOP_DISTANCE = 3'd4;

  // Configuration registers
  typedef struct packed {
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    logic [15:0] gain_linear;
    logic [15:0] gain_angular;
    logic [15:0] stop_distance;
  } cfg_t;

  // Pre-rotated vector and starting angle for one pose request
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [14:0]   hd;
  } seed_t;

  // atan(2^-i) in Q.24 radians
  function automatic logic signed [CW-1:0] atan_q24(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/gtg_if.sv */
// ----------------------------------------------------------------------------
// gtg_if: valid/ready channels of the go-to-goal steering block
// Pose request channel and steering result channel.
// ----------------------------------------------------------------------------
interface gtg_pose_if;
  logic               valid;
  logic               ready;
  logic [15:0]        pose_x;
  logic [15:0]        pose_y;
  logic signed [14:0] pose_heading;

  modport source (output valid, output pose_x, output pose_y, output pose_heading,
                  input ready);
  modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                  output ready);
endinterface

interface gtg_steer_if;
  logic               valid;
  logic               ready;
  logic [22:0]        linear_speed;
  logic signed [23:0] angular_speed;
  logic               reached;

  modport source (output valid, output linear_speed, output angular_speed,
                  output reached, input ready);
  modport sink   (input valid, input linear_speed, input angular_speed,
                  input reached, output ready);
endinterface

/* rtl/gtg_front.sv */
// ----------------------------------------------------------------------------
// gtg_front: pose intake and pre-rotation
// Accepts a pose request, forms the vector to the goal and folds it into the
// right half plane, then offers the seed to the queue.
// ----------------------------------------------------------------------------
module gtg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  gtg_pkg::cfg_t       cfg,
  gtg_pose_if.sink            in_pose,
  output logic                seed_valid,
  input  logic                seed_ready,
  output gtg_pkg::seed_t      seed
);

  logic                            vld_r;
  gtg_pkg::seed_t                  seed_r;
  gtg_pkg::seed_t                  seed_nxt;
  logic signed [16:0]              dx;
  logic signed [16:0]              dy;
  logic signed [gtg_pkg::CW-1:0]   xs;
  logic signed [gtg_pkg::CW-1:0]   ys;
  logic                            take;

  // Accept while the stage is empty or draining into the queue
  assign in_pose.ready = !vld_r || seed_ready;
  assign take          = in_pose.valid && in_pose.ready;

  // Vector to goal, scaled to Q.20
  assign dx = $signed({1'b0, cfg.goal_x}) - $signed({1'b0, in_pose.pose_x});
  assign dy = $signed({1'b0, cfg.goal_y}) - $signed({1'b0, in_pose.pose_y});
  assign xs = {{(gtg_pkg::CW-25){dx[16]}}, dx, 8'b0};
  assign ys = {{(gtg_pkg::CW-25){dy[16]}}, dy, 8'b0};

  // Fold left half plane by rotating through pi
  always_comb begin
    seed_nxt.hd = in_pose.pose_heading;
    if (dx[16]) begin
      seed_nxt.x = -xs;
      seed_nxt.y = -ys;
      seed_nxt.z = dy[16] ? -gtg_pkg::PI_Q24 : gtg_pkg::PI_Q24;
    end else begin
      seed_nxt.x = xs;
      seed_nxt.y = ys;
      seed_nxt.z = '0;
    end
  end

  // Hold valid until the queue takes the seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (seed_ready) begin
      vld_r <= 1'b0;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (take) begin
      seed_r <= seed_nxt;
    end
  end

  assign seed_valid = vld_r;
  assign seed       = seed_r;

endmodule

/* rtl/gtg_queue.sv */
// ----------------------------------------------------------------------------
// gtg_queue: short FIFO between front and back
// Decouples pose intake from the CORDIC pipeline so each side stalls alone.
// ----------------------------------------------------------------------------
module gtg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  gtg_pkg::seed_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output gtg_pkg::seed_t  rd_data
);

  gtg_pkg::seed_t             mem_r [gtg_pkg::Q_DEPTH];
  logic [gtg_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [gtg_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [gtg_pkg::Q_AW:0]     cnt_r;
  logic [gtg_pkg::Q_AW:0]     cnt_nxt;
  logic                       push;
  logic                       pop;

  assign wr_ready = (cnt_r != gtg_pkg::Q_AW'(0) + (gtg_pkg::Q_AW+1)'(gtg_pkg::Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/gtg_back.sv */
// ----------------------------------------------------------------------------
// gtg_back: CORDIC vectoring pipeline and speed computation
// One micro-rotation per stage, then distance scaling, reach test, gain
// multiplies and rounding into the output register.
// ----------------------------------------------------------------------------
module gtg_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gtg_pkg::cfg_t   cfg,
  input  logic            seed_valid,
  output logic            seed_ready,
  input  gtg_pkg::seed_t  seed,
  gtg_steer_if.source     out_steer
);

  localparam int STEPS = (CORDIC_STEPS > gtg_pkg::ATAN_ENTRIES) ?
                         gtg_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CW = gtg_pkg::CW;
  localparam int DW = gtg_pkg::DW;

  logic adv;

  // CORDIC stage registers, index k holds the vector after k rotations
  logic                 cv_r [STEPS+1];
  logic signed [CW-1:0] cx_r [STEPS+1];
  logic signed [CW-1:0] cy_r [STEPS+1];
  logic signed [CW-1:0] cz_r [STEPS+1];
  logic signed [14:0]   ch_r [STEPS+1];

  // Post-processing stages
  logic                      a_vld_r;
  logic [CW+15:0]            a_prod_r;
  logic signed [15:0]        a_bear_r;
  logic signed [14:0]        a_hd_r;
  logic [CW-2:0]             x_clamp;
  logic signed [CW-1:0]      z_round;

  logic                      b_vld_r;
  logic [DW-1:0]             b_dist_r;
  logic                      b_reach_r;
  logic signed [16:0]        b_err_r;
  logic [CW+16:0]            dist_sum;
  logic [DW-1:0]             dist_q12;

  logic                      c_vld_r;
  logic [DW+15:0]            c_lin_r;
  logic signed [33:0]        c_ang_r;
  logic                      c_reach_r;

  logic                      d_vld_r;
  logic [22:0]               d_lin_r;
  logic signed [23:0]        d_ang_r;
  logic                      d_reach_r;
  logic [DW+16:0]            lin_sum;
  logic signed [34:0]        ang_sum;

  // Whole pipeline moves when the output register can take a value
  assign adv        = !d_vld_r || out_steer.ready;
  assign seed_ready = adv;

  // Load stage zero from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= seed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= seed.x;
      cy_r[0] <= seed.y;
      cz_r[0] <= seed.z;
      ch_r[0] <= seed.hd;
    end
  end

  // Micro-rotation stages: drive y toward zero
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (adv) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ch_r[i+1] <= ch_r[i];
        if (cy_r[i] > 0) begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + gtg_pkg::atan_q24(i);
        end else begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - gtg_pkg::atan_q24(i);
        end
      end
    end
  end

  // Stage A: scale magnitude by inverse gain, round angle to Q.12
  assign x_clamp = cx_r[STEPS][CW-1] ? '0 : cx_r[STEPS][CW-2:0];
  assign z_round = cz_r[STEPS] + CW'(2048);

  // Stage B: finish distance, test for reach, form heading error
  assign dist_sum = {1'b0, a_prod_r} + (CW+17)'(1 << 23);
  assign dist_q12 = dist_sum[DW+23:24];

  // Stage D: round gain products
  assign lin_sum = {1'b0, c_lin_r} + (DW+17)'(2048);
  assign ang_sum = {c_ang_r[33], c_ang_r} + 35'sd2048;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= cv_r[STEPS];
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod_r  <= x_clamp * gtg_pkg::INV_GAIN_Q16;
      a_bear_r  <= z_round[CW-1:12];
      a_hd_r    <= ch_r[STEPS];

      b_dist_r  <= dist_q12;
      b_reach_r <= ({2'b0, cfg.stop_distance} >= dist_q12);
      b_err_r   <= {a_bear_r[15], a_bear_r} - {{2{a_hd_r[14]}}, a_hd_r};

      c_lin_r   <= cfg.gain_linear * b_dist_r;
      c_ang_r   <= $signed({1'b0, cfg.gain_angular}) * b_err_r;
      c_reach_r <= b_reach_r;

      d_reach_r <= c_reach_r;
      if (c_reach_r) begin
        d_lin_r <= '0;
        d_ang_r <= '0;
      end else begin
        d_lin_r <= lin_sum[DW+16:12];
        d_ang_r <= {ang_sum[34], ang_sum[34:12]};
      end
    end
  end

  assign out_steer.valid         = d_vld_r;
  assign out_steer.linear_speed  = d_lin_r;
  assign out_steer.angular_speed = d_ang_r;
  assign out_steer.reached       = d_reach_r;

endmodule

/* rtl/go_to_goal_proportional_steer.sv */
// A pose passes the front register, the queue, the CORDIC stages and A to D.
// Throughput: one pose per cycle unless stalled; CORDIC stages set latency.
// A stalled result freezes the back pipeline; the queue keeps intake going.
// Reset (rst_n low, synchronous) empties front, queue and pipeline and loads
// goal (1.0, 1.0), gains 1.0 and 4.0 and stop distance 41.
// ----------------------------------------------------------------------------
// go_to_goal_proportional_steer: proportional go-to-goal controller
// Holds the configuration registers and links front, queue and back.
// ----------------------------------------------------------------------------
module go_to_goal_proportional_steer #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  gtg_pose_if.sink    in_pose,
  gtg_steer_if.source out_steer
);

  gtg_pkg::cfg_t   cfg_r;
  gtg_pkg::seed_t  f_seed;
  gtg_pkg::seed_t  q_seed;
  logic            f_valid;
  logic            f_ready;
  logic            q_valid;
  logic            q_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x        <= 16'd4096;
      cfg_r.goal_y        <= 16'd4096;
      cfg_r.gain_linear   <= 16'd4096;
      cfg_r.gain_angular  <= 16'd16384;
      cfg_r.stop_distance <= 16'd41;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtg_pkg::CFG_GOAL_X:        cfg_r.goal_x        <= cfg_wdata;
        gtg_pkg::CFG_GOAL_Y:        cfg_r.goal_y        <= cfg_wdata;
        gtg_pkg::CFG_GAIN_LINEAR:   cfg_r.gain_linear   <= cfg_wdata;
        gtg_pkg::CFG_GAIN_ANGULAR:  cfg_r.gain_angular  <= cfg_wdata;
        gtg_pkg::CFG_STOP_DISTANCE: cfg_r.stop_distance <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gtg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_pose    (in_pose),
    .seed_valid (f_valid),
    .seed_ready (f_ready),
    .seed       (f_seed)
  );

  gtg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_seed),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_seed)
  );

  gtg_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .seed_valid (q_valid),
    .seed_ready (q_ready),
    .seed       (q_seed),
    .out_steer  (out_steer)
  );

endmodule

/* tb/go_to_goal_proportional_steer_tb.sv */
// ----------------------------------------------------------------------------
// go_to_goal_proportional_steer_tb: self-checking bench for the steering block
// Drives pose requests with random gaps and stalls, predicts each steering
// command with a bit-exact CORDIC model of the block, and checks every result
// in order against it across several register settings.
// ----------------------------------------------------------------------------

// One steering command as the block returns it
typedef struct {
  logic [22:0]        lin;
  logic signed [23:0] ang;
  logic               reached;
} steer_t;

// Predicts steering commands and checks results in arrival order
class steer_board;
  gtg_pkg::cfg_t regs;
  steer_t cmd_q[$];
  int     mismatches;
  int     steps;
  longint atan_tbl[24];

  function new(int n_steps);
    regs.goal_x        = 16'd4096;
    regs.goal_y        = 16'd4096;
    regs.gain_linear   = 16'd4096;
    regs.gain_angular  = 16'd16384;
    regs.stop_distance = 16'd41;
    mismatches = 0;
    steps      = (n_steps > 24) ? 24 : n_steps;
    atan_tbl   = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                   131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
  endfunction

  // Mirror a register write; unknown indexes are dropped
  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      gtg_pkg::CFG_GOAL_X:        regs.goal_x        = val;
      gtg_pkg::CFG_GOAL_Y:        regs.goal_y        = val;
      gtg_pkg::CFG_GAIN_LINEAR:   regs.gain_linear   = val;
      gtg_pkg::CFG_GAIN_ANGULAR:  regs.gain_angular  = val;
      gtg_pkg::CFG_STOP_DISTANCE: regs.stop_distance = val;
      default: ;
    endcase
  endfunction

  // Distance and bearing by vectoring CORDIC, then the proportional law
  function steer_t steer_for_pose(logic [15:0] px, logic [15:0] py,
                                  logic signed [14:0] hd);
    steer_t r;
    longint gx, gy, dx, dy, x, y, z, xs, ys, dist_val, bearing, err, lin, ang, g;
    longint hdl;
    gx  = regs.goal_x;
    gy  = regs.goal_y;
    hdl = hd;
    dx  = gx - longint'(px);
    dy  = gy - longint'(py);
    x   = dx * 256;
    y   = dy * 256;
    z   = 0;
    // fold the left half-plane onto the right one
    if (dx < 0) begin
      z = (dy >= 0) ? 64'sd52707179 : -64'sd52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_tbl[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_tbl[i];
      end
    end
    if (x < 0) x = 0;
    dist_val = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
    g        = regs.stop_distance;
    if (dist_val <= g) begin
      r.lin     = '0;
      r.ang     = '0;
      r.reached = 1'b1;
      return r;
    end
    bearing = (z + 2048) >>> 12;
    err     = bearing - hdl;
    g       = regs.gain_linear;
    lin     = (g * dist_val + 2048) >>> 12;
    if (lin > 8388607) lin = 8388607;
    g       = regs.gain_angular;
    ang     = (g * err + 2048) >>> 12;
    if (ang > 8388607) ang = 8388607;
    if (ang < -8388608) ang = -8388608;
    r.lin     = lin[22:0];
    r.ang     = ang[23:0];
    r.reached = 1'b0;
    return r;
  endfunction

  function void note_pose(logic [15:0] px, logic [15:0] py, logic signed [14:0] hd);
    cmd_q.push_back(steer_for_pose(px, py, hd));
  endfunction

  function void check_steer(steer_t got);
    steer_t want;
    if (cmd_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: lin=%0d ang=%0d reached=%0b",
                 got.lin, got.ang, got.reached);
      return;
    end
    want = cmd_q.pop_front();
    if (got.lin !== want.lin || got.ang !== want.ang || got.reached !== want.reached) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: lin exp %0d got %0d, ang exp %0d got %0d, reached exp %0b got %0b",
                 want.lin, got.lin, want.ang, got.ang, want.reached, got.reached);
    end
  endfunction

  function int pending();
    return cmd_q.size();
  endfunction
endclass

module go_to_goal_proportional_steer_tb;
  localparam int          STEPS          = 16;
  localparam int          RAND_PER_PHASE = 240;
  localparam int          N_PHASES       = 8;
  localparam logic [2:0]  CFG_LAST_INDEX = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // stretch controls shared by the driver processes
  bit no_idle;
  int hold_off_cycles;

  gtg_pose_if  pose_ch();
  gtg_steer_if steer_ch();

  steer_board board;

  go_to_goal_proportional_steer #(
    .CORDIC_STEPS(STEPS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pose   (pose_ch),
    .out_steer (steer_ch)
  );

  // 10-unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    steer_t got;
    if (rst_n && pose_ch.valid && pose_ch.ready)
      board.note_pose(pose_ch.pose_x, pose_ch.pose_y, pose_ch.pose_heading);
    if (rst_n && steer_ch.valid && steer_ch.ready) begin
      got.lin     = steer_ch.linear_speed;
      got.ang     = steer_ch.angular_speed;
      got.reached = steer_ch.reached;
      board.check_steer(got);
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : steer_sink
    int stall;
    steer_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      repeat (stall) begin
        @(negedge clk);
        steer_ch.ready = 1'b0;
      end
      @(negedge clk);
      steer_ch.ready = 1'b1;
      do @(posedge clk); while (!steer_ch.valid);
    end
  end

  // Write one register while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(input logic [15:0] gx, input logic [15:0] gy,
                           input logic [15:0] gl, input logic [15:0] ga,
                           input logic [15:0] sd);
    write_reg(gtg_pkg::CFG_GOAL_X, gx);
    write_reg(gtg_pkg::CFG_GOAL_Y, gy);
    write_reg(gtg_pkg::CFG_GAIN_LINEAR, gl);
    write_reg(gtg_pkg::CFG_GAIN_ANGULAR, ga);
    write_reg(gtg_pkg::CFG_STOP_DISTANCE, sd);
  endtask

  // Offer one pose request after a random gap and hold it until taken
  task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                           input logic signed [14:0] hd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      pose_ch.valid = 1'b0;
    end
    @(negedge clk);
    pose_ch.valid        = 1'b1;
    pose_ch.pose_x       = px;
    pose_ch.pose_y       = py;
    pose_ch.pose_heading = hd;
    do @(posedge clk); while (!pose_ch.ready);
  endtask

  // Mostly in-range poses, some near or at the goal, some with any 16-bit value
  task automatic send_random_pose();
    logic [15:0]        px, py;
    logic signed [14:0] hd;
    int                 kind, reach;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      px = board.regs.goal_x;
      py = board.regs.goal_y;
    end else if (kind < 20) begin
      reach = (board.regs.stop_distance > 2000) ? 2000 : int'(board.regs.stop_distance);
      reach = reach + 16;
      px = 16'(int'(board.regs.goal_x) + int'($urandom_range(0, 2 * reach)) - reach);
      py = 16'(int'(board.regs.goal_y) + int'($urandom_range(0, 2 * reach)) - reach);
    end else if (kind < 32) begin
      px = 16'($urandom);
      py = 16'($urandom);
    end else begin
      px = 16'($urandom_range(0, 45056));
      py = 16'($urandom_range(0, 45056));
    end
    if ($urandom_range(0, 6) == 0)
      hd = 15'($urandom);
    else
      hd = 15'(int'($urandom_range(0, 25736)) - 12868);
    send_pose(px, py, hd);
  endtask

  // Lower valid and wait until every expected command has come back
  task automatic drain();
    @(negedge clk);
    pose_ch.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Corners of the plane, both pre-rotation signs, the axes and the goal itself
  task automatic run_directed();
    send_pose(16'd4096,  16'd4096,  15'sd0);
    send_pose(16'd4116,  16'd4096,  15'sd0);
    send_pose(16'd4096,  16'd4137,  15'sd100);
    send_pose(16'd4096,  16'd4138,  15'sd0);
    send_pose(16'd0,     16'd0,     15'sd0);
    send_pose(16'd45056, 16'd45056, 15'sd12868);
    send_pose(16'd0,     16'd45056, -15'sd12868);
    send_pose(16'd45056, 16'd0,     15'sd16383);
    send_pose(16'd65535, 16'd65535, -15'sd16384);
    send_pose(16'd65535, 16'd0,     15'sd0);
    send_pose(16'd0,     16'd65535, 15'sd1);
    send_pose(16'd8192,  16'd4096,  15'sd0);
    send_pose(16'd8192,  16'd4097,  15'sd0);
    send_pose(16'd8192,  16'd0,     15'sd0);
    send_pose(16'd4096,  16'd0,     15'sd0);
    send_pose(16'd4096,  16'd8192,  15'sd0);
    send_pose(16'd0,     16'd4096,  -15'sd1);
    send_pose(16'd2048,  16'd2048,  15'sd12868);
    send_pose(16'd12345, 16'd54321, -15'sd5000);
    send_pose(16'd1,     16'd1,     15'sd0);
    send_pose(16'd4096,  16'd4095,  -15'sd16384);
    send_pose(16'd45056, 16'd4096,  15'sd16383);
  endtask

  initial begin : stimulus
    logic [2:0] junk_idx;
    board                = new(STEPS);
    no_idle              = 1'b0;
    hold_off_cycles      = 0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = gtg_pkg::CFG_GOAL_X;
    cfg_wdata            = '0;
    pose_ch.valid        = 1'b0;
    pose_ch.pose_x       = '0;
    pose_ch.pose_y       = '0;
    pose_ch.pose_heading = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings first
    run_directed();
    repeat (RAND_PER_PHASE) send_random_pose();
    drain();

    for (int p = 1; p < N_PHASES; p++) begin
      case (p)
        1: write_all(16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0);
        2: write_all(16'd45056, 16'd45056, 16'd0, 16'd0, 16'd65535);
        3: write_all(16'd45056, 16'd0, 16'd4096, 16'd16384, 16'd41);
        4: write_all(16'd0, 16'd45056, 16'($urandom), 16'($urandom), 16'd4096);
        5: begin
          write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 8192)));
          // unused indexes must leave the registers alone
          for (int k = 0; k < 3; k++) begin
            junk_idx = 3'($urandom_range(gtg_pkg::CFG_STOP_DISTANCE + 1, CFG_LAST_INDEX));
            write_reg(junk_idx, 16'($urandom));
          end
        end
        6: write_all(16'd65535, 16'd65535, 16'd1, 16'd1, 16'd1);
        default: write_all(16'($urandom_range(0, 45056)), 16'($urandom_range(0, 45056)),
                           16'($urandom), 16'($urandom), 16'($urandom_range(0, 400)));
      endcase
      // long result hold-off with the sender pushing, then a gap-free stretch
      no_idle = (p == 3 || p == 5);
      if (p == 3) hold_off_cycles = 300;
      repeat (RAND_PER_PHASE) send_random_pose();
      drain();
    end
    no_idle = 1'b0;

    repeat (STEPS + 16) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/gtg_pkg.sv
rtl/gtg_if.sv
rtl/gtg_front.sv
rtl/gtg_queue.sv
rtl/gtg_back.sv
rtl/go_to_goal_proportional_steer.sv
tb/go_to_goal_proportional_steer_tb.sv
